### hdl/modular_vector_matrix_power_assert.svh
// Assertion macros for the modular vector-matrix power unit.
`ifndef MODULAR_VECTOR_MATRIX_POWER_ASSERT_SVH
`define MODULAR_VECTOR_MATRIX_POWER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MVMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define MVMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/mvmp_pkg.sv
// Types and constants of the modular vector-matrix power unit.
`timescale 1ns / 1ps
package mvmp_pkg;

  localparam logic [29:0] MODULUS    = 30'd1000000007;
  localparam logic [30:0] MODULUS_X2 = 31'd2000000014;
  // floor(2^60 / MODULUS), the Barrett reduction factor.
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  typedef enum logic [1:0] {
    KIND_LOAD_VEC = 2'd0,
    KIND_LOAD_MAT = 2'd1,
    KIND_POWER    = 2'd2,
    KIND_READ_VEC = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  row_index;
    logic [6:0]  col_index;
    logic [29:0] elem_value;
    logic [30:0] exponent;
  } item_t;

  typedef struct packed {
    logic [29:0] read_value;
    logic        done_res;
  } result_t;

endpackage

### hdl/modular_vector_matrix_power.sv
// Loads and reads give their result in the cycle after acceptance, one item per cycle while not busy.
// A power item stays busy for one vector pass per set bit of the exponent and one squaring pass
// per bit, each pass issuing one term per cycle through the multiply pipeline and then draining
// it; its result follows the last squaring pass.
// Reset clears control state and sets the dimension to 128; memory contents are undefined.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module modular_vector_matrix_power
  import mvmp_pkg::*;
#(
  parameter int MAX_DIM = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  item_t      item_i,
  output logic       res_valid_o,
  output result_t    res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = IW + 1;
  localparam int CW = (DW > 8) ? DW : 8;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_DIM - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VEC   = 3'd1;
  localparam logic [2:0] S_SQR   = 3'd2;
  localparam logic [2:0] S_DRN_V = 3'd3;
  localparam logic [2:0] S_DRN_S = 3'd4;

  typedef struct packed {
    logic          last;
    logic          zero;
    logic          sqr;
    logic [IW-1:0] o1;
    logic [IW-1:0] o2;
  } tok_t;

  logic [29:0] vec_mem [2**(IW+1)];
  logic [29:0] mat_mem [2**(2*IW+1)];

  logic [2:0]    state_q, state_d;
  logic [7:0]    dim_q;
  logic [30:0]   exp_q, exp_d;
  logic          vsel_q, vsel_d, msel_q, msel_d;
  logic [IW-1:0] o1_q, o1_d, o2_q, o2_d, k_q, k_d;
  logic          res_valid_q, res_valid_d, res_read_q, res_read_d;

  logic [DW-1:0] dim_eff;
  logic [CW-1:0] dim_ext;
  logic          accept, row_ok, col_ok;
  logic [29:0]   val_red;

  logic          iss;
  tok_t          iss_tok;
  logic          elem_last;

  logic [IW:0]     va;
  logic [2*IW:0]   ma, mb;
  logic [29:0]     v_rd_q, ma_rd_q, mb_rd_q;

  logic [6:1]      pv_q;
  tok_t            tok_q [6:1];
  logic [59:0]     p2_q, p3_q;
  logic [61:0]     t3_q;
  logic [31:0]     p4_q, qm4_q, r5_q;
  logic [29:0]     r6_q;
  logic [29:0]     opa;
  logic [60:0]     qm_full;
  logic [29:0]     acc_q, acc_base, acc_new;
  logic [30:0]     acc_sum;
  logic            first_q;

  logic            vwe, mwe;
  logic [IW:0]     vwa;
  logic [2*IW:0]   mwa;
  logic [29:0]     vwd, mwd;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;

  assign dim_ext = CW'(dim_q);
  assign dim_eff = (dim_ext > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(dim_ext);
  assign row_ok  = CW'(item_i.row_index) < CW'(MAX_DIM);
  assign col_ok  = CW'(item_i.col_index) < CW'(MAX_DIM);
  assign val_red = (item_i.elem_value >= MODULUS) ? item_i.elem_value - MODULUS
                                                  : item_i.elem_value;

  // Work sequencer: one multiply term per cycle in a pass, one output element per run of terms.
  always_comb begin
    iss         = (state_q == S_VEC) || (state_q == S_SQR);
    iss_tok.sqr = (state_q == S_SQR);
    iss_tok.o1  = o1_q;
    iss_tok.o2  = o2_q;
    iss_tok.zero = ({1'b0, o2_q} >= dim_eff) ||
                   (iss_tok.sqr && ({1'b0, o1_q} >= dim_eff));
    iss_tok.last = iss_tok.zero || ({1'b0, k_q} == dim_eff - DW'(1));
    elem_last    = (o2_q == IDX_LAST) && (!iss_tok.sqr || (o1_q == IDX_LAST));

    state_d     = state_q;
    exp_d       = exp_q;
    vsel_d      = vsel_q;
    msel_d      = msel_q;
    o1_d        = o1_q;
    o2_d        = o2_q;
    k_d         = k_q;
    res_valid_d = 1'b0;
    res_read_d  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.kind == KIND_POWER && item_i.exponent != 31'd0) begin
            exp_d   = item_i.exponent;
            state_d = item_i.exponent[0] ? S_VEC : S_SQR;
          end else begin
            res_valid_d = 1'b1;
            res_read_d  = (item_i.kind == KIND_READ_VEC) && row_ok;
          end
        end
      end
      S_VEC, S_SQR: begin
        if (iss_tok.last) begin
          k_d  = '0;
          o2_d = (o2_q == IDX_LAST) ? '0 : o2_q + IW'(1);
          if (iss_tok.sqr && o2_q == IDX_LAST) begin
            o1_d = (o1_q == IDX_LAST) ? '0 : o1_q + IW'(1);
          end
          if (elem_last) begin
            o1_d    = '0;
            state_d = iss_tok.sqr ? S_DRN_S : S_DRN_V;
          end
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      S_DRN_V: begin
        if (pv_q == '0) begin
          vsel_d  = ~vsel_q;
          state_d = S_SQR;
        end
      end
      S_DRN_S: begin
        if (pv_q == '0) begin
          msel_d = ~msel_q;
          exp_d  = {1'b0, exp_q[30:1]};
          if (exp_q[30:1] == 30'd0) begin
            state_d     = S_IDLE;
            res_valid_d = 1'b1;
          end else begin
            state_d = exp_q[1] ? S_VEC : S_SQR;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dim_q       <= 8'd128;
      exp_q       <= '0;
      vsel_q      <= 1'b0;
      msel_q      <= 1'b0;
      o1_q        <= '0;
      o2_q        <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
      res_read_q  <= 1'b0;
      pv_q        <= '0;
      first_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      vsel_q      <= vsel_d;
      msel_q      <= msel_d;
      o1_q        <= o1_d;
      o2_q        <= o2_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
      res_read_q  <= res_read_d;
      pv_q        <= {pv_q[5:1], iss};
      if (cfg_valid_i && cfg_ready_o) begin
        dim_q <= cfg_data_i;
      end
      if (pv_q[6]) begin
        first_q <= tok_q[6].last;
      end
    end
  end

  // Read addresses; the vector port serves read items while idle.
  assign va = (state_q == S_IDLE) ? {vsel_q, IW'(item_i.row_index)} : {vsel_q, k_q};
  assign ma = {msel_q, o1_q, k_q};
  assign mb = {msel_q, k_q, o2_q};

  always_ff @(posedge clk_i) begin
    v_rd_q  <= vec_mem[va];
    ma_rd_q <= mat_mem[ma];
    mb_rd_q <= mat_mem[mb];
  end

  // Multiply and Barrett reduction pipeline.
  assign opa     = tok_q[1].zero ? 30'd0 : (tok_q[1].sqr ? ma_rd_q : v_rd_q);
  assign qm_full = 61'(t3_q[61:31]) * 61'(MODULUS);

  always_ff @(posedge clk_i) begin
    tok_q[1] <= iss_tok;
    for (int s = 2; s <= 6; s++) begin
      tok_q[s] <= tok_q[s-1];
    end
    p2_q  <= 60'(opa) * 60'(tok_q[1].zero ? 30'd0 : mb_rd_q);
    t3_q  <= 62'(p2_q[59:29]) * 62'(BARRETT_MU);
    p3_q  <= p2_q;
    p4_q  <= p3_q[31:0];
    qm4_q <= qm_full[31:0];
    r5_q  <= p4_q - qm4_q;
    if (r5_q >= {1'b0, MODULUS_X2}) begin
      r6_q <= 30'(r5_q - {1'b0, MODULUS_X2});
    end else if (r5_q >= {2'b00, MODULUS}) begin
      r6_q <= 30'(r5_q - {2'b00, MODULUS});
    end else begin
      r6_q <= r5_q[29:0];
    end
    if (pv_q[6]) begin
      acc_q <= acc_new;
    end
  end

  assign acc_base = first_q ? 30'd0 : acc_q;
  assign acc_sum  = {1'b0, acc_base} + {1'b0, r6_q};
  assign acc_new  = (acc_sum >= {1'b0, MODULUS}) ? 30'(acc_sum - {1'b0, MODULUS})
                                                  : acc_sum[29:0];

  // Write ports: loads while idle, finished elements into the other bank while working.
  always_comb begin
    vwe = 1'b0;
    vwa = {vsel_q, IW'(item_i.row_index)};
    vwd = val_red;
    mwe = 1'b0;
    mwa = {msel_q, IW'(item_i.row_index), IW'(item_i.col_index)};
    mwd = val_red;
    if (pv_q[6] && tok_q[6].last) begin
      if (tok_q[6].sqr) begin
        mwe = 1'b1;
        mwa = {~msel_q, tok_q[6].o1, tok_q[6].o2};
        mwd = acc_new;
      end else begin
        vwe = 1'b1;
        vwa = {~vsel_q, tok_q[6].o2};
        vwd = acc_new;
      end
    end else if (accept) begin
      vwe = (item_i.kind == KIND_LOAD_VEC) && row_ok;
      mwe = (item_i.kind == KIND_LOAD_MAT) && row_ok && col_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vec_mem[vwa] <= vwd;
    end
    if (mwe) begin
      mat_mem[mwa] <= mwd;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign res_o.read_value = res_read_q ? v_rd_q : 30'd0;
  assign res_o.done_res   = 1'b1;

`include "modular_vector_matrix_power_assert.svh"

  `MVMP_ASSERT_IMP(a_idle_pipe_empty, accept, pv_q == '0, "item accepted with work in flight")
  `MVMP_ASSERT_IMP(a_bank_swap_drained, msel_q != $past(msel_q), $past(pv_q) == '0, "bank swap with work in flight")
  `MVMP_ASSERT_IMP(a_result_cause, res_valid_o, $past(accept) || $past(busy_o), "result without an item")
  `MVMP_ASSERT(a_no_issue_in_drain, !((state_q == S_DRN_V || state_q == S_DRN_S) && iss), "term issued during drain")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the modular vector-matrix power unit.
`timescale 1ns / 1ps
module tb_top;
  import mvmp_pkg::*;

  localparam int DIM_MAX = 128;
  localparam longint unsigned MODV = 64'd1000000007;
  localparam longint unsigned CYCLE_LIMIT = 64'd40000000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  logic    busy_o;
  item_t   item_i = '0;
  logic    res_valid_o;
  result_t res_o;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  modular_vector_matrix_power #(.MAX_DIM(DIM_MAX)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the unit's residues and dimension.
  longint unsigned vec_res[DIM_MAX];
  longint unsigned mat_res[DIM_MAX][DIM_MAX];
  longint unsigned vec_tmp[DIM_MAX];
  longint unsigned mat_tmp[DIM_MAX][DIM_MAX];
  int unsigned dim_reg = 128;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  int      accepted = 0;
  item_t   cur_item;

  function automatic void mul_vector(int d);
    longint unsigned acc;
    for (int i = 0; i < DIM_MAX; i++) vec_tmp[i] = 0;
    for (int c = 0; c < d; c++) begin
      acc = 0;
      for (int r = 0; r < d; r++) acc = (acc + vec_res[r] * mat_res[r][c]) % MODV;
      vec_tmp[c] = acc;
    end
    vec_res = vec_tmp;
  endfunction

  function automatic void square_matrix(int d);
    longint unsigned acc;
    for (int r = 0; r < DIM_MAX; r++)
      for (int c = 0; c < DIM_MAX; c++) mat_tmp[r][c] = 0;
    for (int r = 0; r < d; r++)
      for (int c = 0; c < d; c++) begin
        acc = 0;
        for (int k = 0; k < d; k++) acc = (acc + mat_res[r][k] * mat_res[k][c]) % MODV;
        mat_tmp[r][c] = acc;
      end
    mat_res = mat_tmp;
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t res;
    longint unsigned v;
    int d;
    logic [30:0] e;
    res = '0;
    res.done_res = 1'b1;
    v = it.elem_value;
    if (v >= MODV) v = v - MODV;
    case (it.kind)
      KIND_LOAD_VEC: vec_res[it.row_index] = v;
      KIND_LOAD_MAT: mat_res[it.row_index][it.col_index] = v;
      KIND_POWER: begin
        d = (dim_reg > DIM_MAX) ? DIM_MAX : dim_reg;
        e = it.exponent;
        while (e != 0) begin
          if (e[0]) mul_vector(d);
          e = e >> 1;
          square_matrix(d);
        end
      end
      default: res.read_value = vec_res[it.row_index][29:0];
    endcase
    return res;
  endfunction

  // Driver: one item presented at a time, idling at random except while the accepted count is between 600 and 900.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(apply_item(cur_item));
        accepted++;
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() != 0 &&
            ((accepted > 600 && accepted < 900) || $urandom_range(99) >= 17)) begin
          cur_item = pending_items.pop_front();
          start_i <= 1'b1;
          item_i  <= cur_item;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, res_o);
        errors++;
      end else begin
        if (res_o.read_value !== expected_results[0].read_value ||
            res_o.done_res !== expected_results[0].done_res) begin
          $display("%0t: mismatch, expected value %0d done %0b, actual value %0d done %0b",
                   $realtime, expected_results[0].read_value, expected_results[0].done_res,
                   res_o.read_value, res_o.done_res);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  longint unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Generator bookkeeping of which entries hold a defined value.
  bit vec_known[DIM_MAX];
  bit mat_known[DIM_MAX][DIM_MAX];
  int gen_dim = 128;

  task automatic add_item(kind_e k, int r, int c, logic [29:0] val, logic [30:0] e);
    item_t it;
    int d;
    it.kind = k;
    it.row_index = r[6:0];
    it.col_index = c[6:0];
    it.elem_value = val;
    it.exponent = e;
    d = (gen_dim > DIM_MAX) ? DIM_MAX : gen_dim;
    case (k)
      KIND_LOAD_VEC: vec_known[r] = 1'b1;
      KIND_LOAD_MAT: mat_known[r][c] = 1'b1;
      KIND_POWER: begin
        // The step reads the whole live vector and matrix: define them first.
        for (int i = 0; i < d; i++)
          if (!vec_known[i]) add_item(KIND_LOAD_VEC, i, 0, 30'($urandom), 31'd0);
        for (int i = 0; i < d; i++)
          for (int j = 0; j < d; j++)
            if (!mat_known[i][j]) add_item(KIND_LOAD_MAT, i, j, 30'($urandom), 31'd0);
        if (e != 0) begin
          foreach (vec_known[i]) vec_known[i] = 1'b1;
          foreach (mat_known[i, j]) mat_known[i][j] = 1'b1;
        end
      end
      default: if (!vec_known[r]) add_item(KIND_LOAD_VEC, r, 0, 30'($urandom), 31'd0);
    endcase
    pending_items.push_back(it);
  endtask

  task automatic write_dim(logic [7:0] val);
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    @(posedge clk_i);
    while (busy_o || start_i) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    dim_reg = val;
    gen_dim = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int d, k, r, c;
    logic [30:0] e;
    d = (gen_dim > DIM_MAX) ? DIM_MAX : gen_dim;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if ($urandom_range(9) < 7 && d > 0) begin
        r = $urandom_range(d - 1);
        c = $urandom_range(d - 1);
      end else begin
        r = $urandom_range(127);
        c = $urandom_range(127);
      end
      if (k < 2 && d <= 3) begin
        e = (d == 0) ? 31'($urandom) : 31'($urandom_range(3));
        add_item(KIND_POWER, r, c, 30'($urandom), e);
      end else if (k < 36) begin
        add_item(KIND_LOAD_VEC, r, c, 30'($urandom), 31'($urandom));
      end else if (k < 66) begin
        add_item(KIND_LOAD_MAT, r, c, 30'($urandom), 31'($urandom));
      end else begin
        add_item(KIND_READ_VEC, r, c, 30'($urandom), 31'($urandom));
      end
    end
  endtask

  initial begin
    int dims[7] = '{2, 255, 3, 1, 128, 0, 2};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_dim(8'd1);
    add_item(KIND_LOAD_VEC, 0, 0, 30'h3FFFFFFF, 0);
    add_item(KIND_LOAD_VEC, 127, 0, 30'd0, 0);
    add_item(KIND_LOAD_MAT, 127, 127, 30'd1000000007, 0);
    add_item(KIND_LOAD_MAT, 0, 0, 30'd1000000006, 0);
    add_item(KIND_READ_VEC, 127, 0, 0, 0);
    add_item(KIND_READ_VEC, 0, 0, 0, 0);
    add_item(KIND_POWER, 0, 0, 0, 31'd0);
    add_item(KIND_READ_VEC, 0, 0, 0, 0);
    add_item(KIND_POWER, 0, 0, 0, 31'd1);
    add_item(KIND_READ_VEC, 0, 0, 0, 0);
    add_item(KIND_POWER, 0, 0, 0, 31'd2);
    add_item(KIND_READ_VEC, 0, 0, 0, 0);
    add_item(KIND_LOAD_VEC, 1, 0, 30'd1000000006, 0);
    add_item(KIND_READ_VEC, 1, 0, 0, 0);
    add_item(KIND_READ_VEC, 127, 0, 0, 0);
    write_dim(8'd0);
    add_item(KIND_POWER, 0, 0, 0, 31'h7FFFFFFF);
    add_item(KIND_READ_VEC, 0, 0, 0, 0);
    add_item(KIND_READ_VEC, 5, 0, 0, 0);

    foreach (dims[i]) begin
      write_dim(dims[i][7:0]);
      random_phase(255);
    end

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/mvmp_pkg.sv
hdl/modular_vector_matrix_power.sv
tb/tb_top.sv
